// ===== design/ispf_pkg.sv =====
`timescale 1ns / 1ps

package ispf_pkg;

    // Field widths of the item and configuration registers.
    localparam int KIND_W        = 2;
    localparam int FB_RAW_W      = 32;
    localparam int FB_LEN_W      = 3;
    localparam int BYTES_W       = 13;
    localparam int FRAMES_W      = 17;
    localparam int SRATE_W       = 20;
    localparam int DEPTH_W       = 6;
    localparam int CHANS_W       = 8;
    localparam int MAXPKT_W      = 16;
    localparam int CLASS_W       = 2;
    localparam int BPF_W         = 11;
    localparam int BASE_W        = 11;
    localparam int MULT_W        = 2;
    localparam int DIVISOR_W     = 13;
    localparam int FB_NATIVE     = 16;

    // APB port geometry.
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_PACKET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FEEDBACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART  = 2'd2;

    // Register indexes (word address).
    localparam logic [2:0] REG_SAMPLE_RATE   = 3'd0;
    localparam logic [2:0] REG_BIT_DEPTH     = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_HIGH_SPEED    = 3'd3;
    localparam logic [2:0] REG_MAX_PACKET    = 3'd4;
    localparam logic [2:0] REG_CLASS_VERSION = 3'd5;

    // Register reset values.
    localparam logic [SRATE_W-1:0]  RST_SAMPLE_RATE   = 20'd48000;
    localparam logic [DEPTH_W-1:0]  RST_BIT_DEPTH     = 6'd16;
    localparam logic [CHANS_W-1:0]  RST_CHANNEL_COUNT = 8'd2;
    localparam logic                RST_HIGH_SPEED    = 1'b0;
    localparam logic [MAXPKT_W-1:0] RST_MAX_PACKET    = 16'd192;
    localparam logic [CLASS_W-1:0]  RST_CLASS_VERSION = 2'd1;

    // Feedback format selection.
    localparam logic [CLASS_W-1:0]  CLASS_V2          = 2'd2;
    localparam logic [FB_LEN_W-1:0] FB_LEN_MIN        = 3'd3;
    localparam logic [FB_LEN_W-1:0] FB_LEN_FULL       = 3'd4;

    // Packets per second in full speed and high speed.
    localparam logic [DIVISOR_W-1:0] PKT_RATE_FULL    = 13'd1000;
    localparam logic [DIVISOR_W-1:0] PKT_RATE_HIGH    = 13'd8000;

    // Nominal rate: 1000 = 125 * 8 and 8000 = 1000 * 8. The odd factor 125
    // is removed by multiplying with its rounded-up reciprocal.
    localparam int                   DIV_ODD_W        = 7;
    localparam logic [DIV_ODD_W-1:0] DIV_ODD          = 7'd125;
    localparam int                   DIV_POW2         = 3;
    localparam int                   HS_SHIFT         = 3;
    localparam int                   RECIP_SHIFT      = SRATE_W + DIV_ODD_W;
    localparam logic [SRATE_W:0]     RECIP_RATE       = 21'd1073742;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [FB_RAW_W-1:0] feedback_raw;
        logic [FB_LEN_W-1:0] feedback_length;
    } in_item_t;

    typedef struct packed {
        logic [BYTES_W-1:0]  packet_bytes;
        logic [FRAMES_W-1:0] frame_count;
        logic                was_capped;
    } out_item_t;

    typedef struct packed {
        logic [SRATE_W-1:0]  sample_rate;
        logic [DEPTH_W-1:0]  bit_depth;
        logic [CHANS_W-1:0]  channel_count;
        logic                high_speed;
        logic [MAXPKT_W-1:0] max_packet_word;
        logic [CLASS_W-1:0]  class_version;
    } cfg_t;

    // Values derived from the configuration, registered from the configuration registers.
    typedef struct packed {
        logic [BPF_W-1:0]   bytes_per_frame;
        logic [BYTES_W-1:0] max_bytes;
    } derived_t;

endpackage

// ===== design/iso_packet_size_from_feedback_core.sv =====
`timescale 1ns / 1ps

// Isochronous audio OUT packet sizer. Each packet request adds the frame rate
// per packet (the last feedback value, or the nominal sample_rate/1000 or
// sample_rate/8000 while no feedback is stored) to a fractional accumulator
// and returns the whole frames, the byte count capped at the effective max
// packet and a capped flag; feedback and restart items update the state and
// return nothing. One item is taken every cycle; a result passes through the
// input register and then the result register, and a packet request waiting
// behind a result that has not been taken holds s_ready low. The nominal rate
// comes from a three-stage reciprocal multiply that settles after reset and
// after every register write: s_ready stays low while the APB port is
// selected and while the nominal rate settles after each write or the end of
// reset, which sets the only other gap in the one-item-per-cycle rate.
module iso_packet_size_from_feedback_core
    import ispf_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t                       cfg;
    derived_t                   derived;
    logic                       cfg_write;
    logic [FRACTION_BITS+15:0]  nominal_rate;
    logic                       div_busy;
    logic                       hold;

    // Items wait while the port is in use or the nominal rate is settling.
    assign hold = div_busy || psel;

    ispf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .derived   (derived),
        .cfg_write (cfg_write)
    );

    ispf_nominal_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_nominal_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cfg_write    (cfg_write),
        .nominal_rate (nominal_rate),
        .busy         (div_busy)
    );

    ispf_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .cfg          (cfg),
        .derived      (derived),
        .nominal_rate (nominal_rate),
        .hold         (hold)
    );

endmodule

// ===== design/ispf_cfg_regs.sv =====
`timescale 1ns / 1ps

module ispf_cfg_regs
    import ispf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg,
    output derived_t              derived,
    output logic                  cfg_write
);

    cfg_t       cfg_reg;
    derived_t   derived_reg;
    derived_t   derived_next;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_rate     <= RST_SAMPLE_RATE;
            cfg_reg.bit_depth       <= RST_BIT_DEPTH;
            cfg_reg.channel_count   <= RST_CHANNEL_COUNT;
            cfg_reg.high_speed      <= RST_HIGH_SPEED;
            cfg_reg.max_packet_word <= RST_MAX_PACKET;
            cfg_reg.class_version   <= RST_CLASS_VERSION;
        end else if (cfg_write) begin
            case (reg_index)
                REG_SAMPLE_RATE:   cfg_reg.sample_rate     <= pwdata[SRATE_W-1:0];
                REG_BIT_DEPTH:     cfg_reg.bit_depth       <= pwdata[DEPTH_W-1:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count   <= pwdata[CHANS_W-1:0];
                REG_HIGH_SPEED:    cfg_reg.high_speed      <= pwdata[0];
                REG_MAX_PACKET:    cfg_reg.max_packet_word <= pwdata[MAXPKT_W-1:0];
                REG_CLASS_VERSION: cfg_reg.class_version   <= pwdata[CLASS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data multiplexer.
    always_comb begin
        prdata = '0;
        case (reg_index)
            REG_SAMPLE_RATE:   prdata = APB_DATA_W'(cfg_reg.sample_rate);
            REG_BIT_DEPTH:     prdata = APB_DATA_W'(cfg_reg.bit_depth);
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(cfg_reg.channel_count);
            REG_HIGH_SPEED:    prdata = APB_DATA_W'(cfg_reg.high_speed);
            REG_MAX_PACKET:    prdata = APB_DATA_W'(cfg_reg.max_packet_word);
            REG_CLASS_VERSION: prdata = APB_DATA_W'(cfg_reg.class_version);
            default:           prdata = '0;
        endcase
    end

    // Bytes per frame and the effective max packet, registered in the cycle after the registers.
    always_comb begin
        derived_next.bytes_per_frame = BPF_W'(cfg_reg.bit_depth[DEPTH_W-1:3])
                                       * BPF_W'(cfg_reg.channel_count);
        derived_next.max_bytes = BYTES_W'(cfg_reg.max_packet_word[BASE_W-1:0])
                                 * (BYTES_W'(cfg_reg.max_packet_word[BASE_W+MULT_W-1:BASE_W])
                                    + BYTES_W'(1));
    end

    always_ff @(posedge aclk) begin
        derived_reg <= derived_next;
    end

    assign cfg     = cfg_reg;
    assign derived = derived_reg;

endmodule

// ===== design/ispf_nominal_div.sv =====
`timescale 1ns / 1ps

module ispf_nominal_div
    import ispf_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  logic                          cfg_write,
    output logic [FRACTION_BITS+15:0]     nominal_rate,
    output logic                          busy
);

    localparam int RATE_W     = FRACTION_BITS + FB_NATIVE;
    localparam int QUOT_W     = SRATE_W - DIV_ODD_W + 1;
    localparam int FPART_W    = FRACTION_BITS - DIV_POW2;
    localparam int NOM_W      = QUOT_W + FPART_W;
    localparam int QPROD_W    = 2 * SRATE_W + 1;
    localparam int RECIP_W    = FRACTION_BITS + 5;
    localparam int RECIP_K    = FPART_W + 2 * DIV_ODD_W;
    localparam int FRAC_SHIFT = 2 * DIV_ODD_W;
    localparam int FPROD_W    = DIV_ODD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] FRAC_RECIP =
        RECIP_W'(((64'd1 << RECIP_K) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));
    localparam int                  SETTLE_W      = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    logic [QPROD_W-1:0]   q_prod;
    logic [QUOT_W-1:0]    quot_reg;
    logic [QUOT_W-1:0]    quot_keep_reg;
    logic [SRATE_W-1:0]   srate_reg;
    logic [SRATE_W-1:0]   rem_wide;
    logic [DIV_ODD_W-1:0] rem_reg;
    logic [FPROD_W-1:0]   f_prod;
    logic [FPART_W-1:0]   frac_part;
    logic [NOM_W-1:0]     nom_full;
    logic [RATE_W-1:0]    nominal_reg;
    logic [SETTLE_W-1:0]  settle_reg;

    // The rate is floor(sample_rate * 2^FRACTION_BITS / 1000). With
    // sample_rate = 125 * q + r this is q followed by FRACTION_BITS - 3
    // fraction bits that equal floor(r * 2^(FRACTION_BITS - 3) / 125).
    always_comb begin
        q_prod    = QPROD_W'(cfg.sample_rate) * QPROD_W'(RECIP_RATE);
        rem_wide  = srate_reg - SRATE_W'(quot_reg) * SRATE_W'(DIV_ODD);
        f_prod    = FPROD_W'(rem_reg) * FPROD_W'(FRAC_RECIP);
        frac_part = f_prod[FRAC_SHIFT+FPART_W-1:FRAC_SHIFT];
        nom_full  = {quot_keep_reg, frac_part};
    end

    // Three free-running stages: quotient, remainder, then the fraction bits.
    // High speed divides the full-speed rate by another 8.
    always_ff @(posedge aclk) begin
        quot_reg      <= q_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        srate_reg     <= cfg.sample_rate;
        rem_reg       <= rem_wide[DIV_ODD_W-1:0];
        quot_keep_reg <= quot_reg;
        nominal_reg   <= cfg.high_speed ? RATE_W'(nom_full >> HS_SHIFT) : RATE_W'(nom_full);
    end

    // Busy is held while the result settles after reset and after every register write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (cfg_write) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - SETTLE_W'(1);
        end
    end

    assign busy         = settle_reg != '0;
    assign nominal_rate = nominal_reg;

endmodule

// ===== design/ispf_datapath.sv =====
`timescale 1ns / 1ps

module ispf_datapath
    import ispf_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_item,
    input  cfg_t                      cfg,
    input  derived_t                  derived,
    input  logic [FRACTION_BITS+15:0] nominal_rate,
    input  logic                      hold
);

    localparam int RATE_W = FRACTION_BITS + FB_NATIVE;
    localparam int WANT_W = FRAMES_W + BPF_W;

    logic                     in_valid_reg;
    in_item_t                 in_item_reg;
    logic                     out_valid_reg;
    out_item_t                out_item_reg;
    out_item_t                out_item_next;
    logic [FB_RAW_W-1:0]      feedback_rate_reg;
    logic [FB_RAW_W-1:0]      feedback_rate_next;
    logic [FRACTION_BITS-1:0] fraction_reg;
    logic [FRACTION_BITS-1:0] fraction_next;
    logic [RATE_W-1:0]        fb_rate;
    logic [RATE_W-1:0]        rate;
    logic [RATE_W:0]          sum;
    logic [FRAMES_W-1:0]      frames;
    logic [WANT_W-1:0]        want;
    logic                     capped;
    logic                     is_packet;
    logic                     advance;
    logic                     s_take;

    // Stored 16.16 rate brought to the accumulator's fraction width.
    if (FRACTION_BITS >= FB_NATIVE) begin : g_rate_up
        assign fb_rate = RATE_W'(feedback_rate_reg) << (FRACTION_BITS - FB_NATIVE);
    end else begin : g_rate_down
        assign fb_rate = RATE_W'(feedback_rate_reg >> (FB_NATIVE - FRACTION_BITS));
    end

    // Handshake: an item moves on unless it needs the result register and that is full.
    assign is_packet = in_item_reg.kind == KIND_PACKET;
    assign advance   = in_valid_reg && (!is_packet || !out_valid_reg || m_ready);
    assign s_ready   = !hold && (!in_valid_reg || advance);
    assign s_take    = s_valid && s_ready;

    // Accumulator step and byte count for a packet request.
    always_comb begin
        rate   = (feedback_rate_reg != '0) ? fb_rate : nominal_rate;
        sum    = {1'b0, rate} + (RATE_W + 1)'(fraction_reg);
        frames = sum[RATE_W:FRACTION_BITS];
        want   = WANT_W'(frames) * WANT_W'(derived.bytes_per_frame);
        capped = want > WANT_W'(derived.max_bytes);

        out_item_next.frame_count  = frames;
        out_item_next.was_capped   = capped;
        out_item_next.packet_bytes = capped ? derived.max_bytes : want[BYTES_W-1:0];
    end

    // State update for every kind of item.
    always_comb begin
        feedback_rate_next = feedback_rate_reg;
        fraction_next      = fraction_reg;
        case (in_item_reg.kind)
            KIND_PACKET: begin
                fraction_next = sum[FRACTION_BITS-1:0];
            end
            KIND_FEEDBACK: begin
                if (in_item_reg.feedback_length >= FB_LEN_FULL) begin
                    feedback_rate_next = in_item_reg.feedback_raw;
                end else if (in_item_reg.feedback_length == FB_LEN_MIN) begin
                    if (cfg.class_version == CLASS_V2) begin
                        feedback_rate_next = {8'd0, in_item_reg.feedback_raw[23:0]};
                    end else begin
                        feedback_rate_next = {6'd0, in_item_reg.feedback_raw[23:0], 2'b00};
                    end
                end
            end
            KIND_RESTART: begin
                feedback_rate_next = '0;
                fraction_next      = '0;
            end
            default: ;
        endcase
    end

    // Input register, state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            feedback_rate_reg <= '0;
            fraction_reg      <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance && is_packet) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                feedback_rate_reg <= feedback_rate_next;
                fraction_reg      <= fraction_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
        if (advance && is_packet) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
